FILE: src/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// When the trigger holds, the consequence holds in the cycle after.
`define ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/tde_pkg.sv
// Types and constants of the tree diameter engine.
`default_nettype none
package tde_pkg;
    localparam int MAX_VERTICES = 1024;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int LINK_SLOTS   = 2 * MAX_VERTICES;
    localparam int SLOT_W       = $clog2(LINK_SLOTS);
    localparam int DEPTH_W      = VTX_W + 1;
    localparam int HGT_W        = VTX_W + 1;
    localparam int BEST_W       = HGT_W + 1;
    localparam int DIAM_W       = 10;
    localparam int DIAM_MAX     = 1023;

    typedef struct packed {
        logic [VTX_W-1:0]  vtx;
        logic [SLOT_W-1:0] cur;
        logic [HGT_W-1:0]  hgt;
    } t_frame;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_TAIL_RD,
        OP_APPEND,
        OP_NEXT_END,
        OP_INIT,
        OP_HEAD,
        OP_LINK_RD,
        OP_NBR_RD,
        OP_STEP,
        OP_POP,
        OP_MERGE,
        OP_FINISH,
        OP_RESULT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic side;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic drop;
        logic ans_ready;
        logic cur_zero;
        logic depth_zero;
        logic out_free;
    } t_stat;
endpackage
`default_nettype wire

FILE: src/tde_req_if.sv
// Request channel: edge loads and diameter queries.
`default_nettype none
interface tde_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [9:0] node_u;
    logic [9:0] node_w;
    modport source (output valid, req_type, node_u, node_w, input ready);
    modport sink   (input valid, req_type, node_u, node_w, output ready);
endinterface
`default_nettype wire

FILE: src/tde_rsp_if.sv
// Response channel: diameter and drop status.
`default_nettype none
interface tde_rsp_if;
    logic       valid;
    logic       ready;
    logic [9:0] diameter;
    logic       status;
    modport source (output valid, diameter, status, input ready);
    modport sink   (input valid, diameter, status, output ready);
endinterface
`default_nettype wire

FILE: src/tde_dpath.sv
// Datapath: adjacency store, visit marks, walk stack and result register.
`default_nettype none
`include "assert_macros.svh"
module tde_dpath (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  tde_pkg::t_cmd     i_cmd,
    input  wire               i_req_type,
    input  wire  [9:0]        i_node_u,
    input  wire  [9:0]        i_node_w,
    input  wire               i_out_ready,
    output tde_pkg::t_stat    o_stat,
    output logic              o_out_valid,
    output logic [9:0]        o_diameter,
    output logic              o_status
);
    import tde_pkg::*;

    logic [SLOT_W-1:0]  m_head [MAX_VERTICES];
    logic [SLOT_W-1:0]  m_tail [MAX_VERTICES];
    logic               m_mark [MAX_VERTICES];
    logic [VTX_W-1:0]   m_tgt  [LINK_SLOTS];
    logic [SLOT_W-1:0]  m_nxt  [LINK_SLOTS];
    t_frame             m_stk  [MAX_VERTICES];

    logic [VTX_W-1:0]   r_clr_idx;
    logic [VTX_W-1:0]   r_u, r_w;
    logic               r_isq, r_drop;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_parity, r_ans;
    logic [DIAM_W-1:0]  r_best_len;
    logic [BEST_W-1:0]  r_best;
    logic [VTX_W-1:0]   r_top_v;
    logic [SLOT_W-1:0]  r_top_cur;
    logic [HGT_W-1:0]   r_top_h;
    logic [DEPTH_W-1:0] r_depth;
    logic [HGT_W-1:0]   r_dist;
    logic [SLOT_W-1:0]  r_tail_q, r_head_q, r_nxt_q;
    logic [VTX_W-1:0]   r_tgt_q;
    logic               r_mark_q;
    t_frame             r_stk_q;
    logic               r_ovalid;
    logic [DIAM_W-1:0]  r_odiam;
    logic               r_ostat;

    logic [VTX_W-1:0]   from_v, to_v;
    logic               visit;
    logic [BEST_W-1:0]  sum;
    logic [VTX_W-1:0]   push_idx, pop_idx;

    always_comb begin
        from_v   = i_cmd.side ? r_w : r_u;
        to_v     = i_cmd.side ? r_u : r_w;
        visit    = (r_mark_q == r_parity) && (r_depth < DEPTH_W'(MAX_VERTICES));
        sum      = BEST_W'(r_dist) + BEST_W'(r_stk_q.hgt);
        push_idx = VTX_W'(r_depth - DEPTH_W'(1));
        pop_idx  = VTX_W'(r_depth - DEPTH_W'(2));
    end

    // Per-vertex head and tail pointers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CLR: begin
                m_head[r_clr_idx] <= '0;
                m_tail[r_clr_idx] <= '0;
            end
            OP_APPEND: begin
                m_tail[from_v] <= r_slot;
                if (r_tail_q == '0) begin
                    m_head[from_v] <= r_slot;
                end
            end
            OP_TAIL_RD: r_tail_q <= m_tail[from_v];
            OP_INIT:    r_head_q <= m_head[VTX_W'(1)];
            OP_NBR_RD:  r_head_q <= m_head[r_tgt_q];
            default: ;
        endcase
    end

    // Visit marks.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CLR:    m_mark[r_clr_idx] <= 1'b0;
            OP_INIT:   m_mark[VTX_W'(1)] <= ~r_parity;
            OP_NBR_RD: r_mark_q <= m_mark[r_tgt_q];
            OP_STEP: begin
                if (visit) begin
                    m_mark[r_tgt_q] <= ~r_parity;
                end
            end
            default: ;
        endcase
    end

    // Link store.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_APPEND: begin
                m_tgt[r_slot] <= to_v;
                if (r_tail_q != '0) begin
                    m_nxt[r_tail_q] <= r_slot;
                end
            end
            OP_NEXT_END: m_nxt[r_slot] <= '0;
            OP_LINK_RD: begin
                r_tgt_q <= m_tgt[r_top_cur];
                r_nxt_q <= m_nxt[r_top_cur];
            end
            default: ;
        endcase
    end

    // Walk stack holds every frame below the top one.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_STEP && visit) begin
            m_stk[push_idx] <= '{vtx: r_top_v, cur: r_top_cur, hgt: r_top_h};
        end
        if (i_cmd.op == OP_POP) begin
            r_stk_q <= m_stk[pop_idx];
        end
    end

    // Payload registers of the walk and the request.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_u   <= i_node_u;
                r_w   <= i_node_w;
                r_isq <= i_req_type;
            end
            OP_HEAD: r_top_cur <= r_head_q;
            OP_NBR_RD: r_top_cur <= r_nxt_q;
            OP_STEP: begin
                if (visit) begin
                    r_top_v   <= r_tgt_q;
                    r_top_cur <= r_head_q;
                    r_top_h   <= '0;
                end
            end
            OP_INIT: begin
                r_top_v <= VTX_W'(1);
                r_top_h <= '0;
                r_best  <= '0;
            end
            OP_POP: r_dist <= r_top_h + HGT_W'(1);
            OP_MERGE: begin
                r_top_v   <= r_stk_q.vtx;
                r_top_cur <= r_stk_q.cur;
                r_top_h   <= (r_dist > r_stk_q.hgt) ? r_dist : r_stk_q.hgt;
                if (sum > r_best) begin
                    r_best <= sum;
                end
            end
            OP_RESULT: begin
                r_odiam <= r_isq ? r_best_len : '0;
                r_ostat <= r_drop;
            end
            default: ;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_slot     <= SLOT_W'(1);
            r_parity   <= 1'b0;
            r_ans      <= 1'b0;
            r_best_len <= '0;
            r_depth    <= '0;
            r_drop     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                OP_CLR:      r_clr_idx <= r_clr_idx + VTX_W'(1);
                OP_LOAD:     r_drop <= !i_req_type && (r_slot > SLOT_W'(LINK_SLOTS - 2));
                OP_NEXT_END: r_slot <= r_slot + SLOT_W'(1);
                OP_INIT:     r_depth <= DEPTH_W'(1);
                OP_STEP: begin
                    if (visit) begin
                        r_depth <= r_depth + DEPTH_W'(1);
                    end
                end
                OP_POP:      r_depth <= r_depth - DEPTH_W'(1);
                OP_FINISH: begin
                    r_parity   <= ~r_parity;
                    r_ans      <= 1'b1;
                    r_best_len <= (r_best > BEST_W'(DIAM_MAX)) ? DIAM_W'(DIAM_MAX)
                                                                : DIAM_W'(r_best);
                end
                OP_RESULT:   r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.clr_last   = (r_clr_idx == VTX_W'(MAX_VERTICES - 1));
        o_stat.is_query   = r_isq;
        o_stat.drop       = r_drop;
        o_stat.ans_ready  = r_ans;
        o_stat.cur_zero   = (r_top_cur == '0);
        o_stat.depth_zero = (r_depth == '0);
        o_stat.out_free   = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_diameter  = r_odiam;
    assign o_status    = r_ostat;

    `ASSERT_ALWAYS(a_depth_bound, r_depth <= DEPTH_W'(MAX_VERTICES))
    `ASSERT_ALWAYS(a_slot_bound, r_slot != '0)
    `ASSERT_NEXT(a_ans_sticky, r_ans, r_ans)
    `ASSERT_NEXT(a_push_grows, i_cmd.op == OP_STEP && visit, r_depth == $past(r_depth) + DEPTH_W'(1))
endmodule
`default_nettype wire

FILE: src/tde_ctrl.sv
// Controller: sequences clearing, edge appends and the depth-first walk.
`default_nettype none
`include "assert_macros.svh"
module tde_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  tde_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output tde_pkg::t_cmd  o_cmd
);
    import tde_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_DECIDE = 13'b0000000000100,
        S_TAIL   = 13'b0000000001000,
        S_APPEND = 13'b0000000010000,
        S_END    = 13'b0000000100000,
        S_INIT   = 13'b0000001000000,
        S_HEAD   = 13'b0000010000000,
        S_TOP    = 13'b0000100000000,
        S_NBR    = 13'b0001000000000,
        S_STEP   = 13'b0010000000000,
        S_POPD   = 13'b0100000000000,
        S_RESP   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_side, n_side;

    always_comb begin
        n_state    = r_state;
        n_side     = r_side;
        o_cmd.op   = OP_NONE;
        o_cmd.side = r_side;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_side = 1'b0;
                if (i_stat.is_query) begin
                    n_state = i_stat.ans_ready ? S_RESP : S_INIT;
                end else begin
                    n_state = i_stat.drop ? S_RESP : S_TAIL;
                end
            end
            S_TAIL: begin
                o_cmd.op = OP_TAIL_RD;
                n_state  = S_APPEND;
            end
            S_APPEND: begin
                o_cmd.op = OP_APPEND;
                n_state  = S_END;
            end
            S_END: begin
                o_cmd.op = OP_NEXT_END;
                n_side   = 1'b1;
                n_state  = r_side ? S_RESP : S_TAIL;
            end
            S_INIT: begin
                o_cmd.op = OP_INIT;
                n_state  = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.op = OP_HEAD;
                n_state  = S_TOP;
            end
            S_TOP: begin
                if (i_stat.cur_zero) begin
                    o_cmd.op = OP_POP;
                    n_state  = S_POPD;
                end else begin
                    o_cmd.op = OP_LINK_RD;
                    n_state  = S_NBR;
                end
            end
            S_NBR: begin
                o_cmd.op = OP_NBR_RD;
                n_state  = S_STEP;
            end
            S_STEP: begin
                o_cmd.op = OP_STEP;
                n_state  = S_TOP;
            end
            S_POPD: begin
                if (i_stat.depth_zero) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.op = OP_MERGE;
                    n_state  = S_TOP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_side  <= n_side;
        end
    end

    `ASSERT_ALWAYS(a_onehot_state, $onehot(r_state))
    `ASSERT_NEXT(a_accept_decides, o_in_ready && i_in_valid, r_state == S_DECIDE)
    `ASSERT_NEXT(a_step_loops, r_state == S_STEP, r_state == S_TOP)
endmodule
`default_nettype wire

FILE: src/tree_diameter_engine.sv
// Top level of the tree diameter engine.
// Requests arrive on i_req: req_type 0 adds the edge node_u - node_w, req_type 1
// asks for the diameter of the tree that holds vertex 1. Each request gives one
// transaction on o_rsp: diameter (zero on an add) and status (1 when an edge was
// dropped because the link store is full).
// After reset the block sweeps its vertex tables and holds i_req.ready low; then
// it takes one request at a time.
// An edge add runs, for each endpoint, a tail read, a write of the link and list
// pointers, and a write that ends the new link. A dropped edge skips these steps
// and goes straight to its response. The first query walks the tree on
// single-port memories; later queries return the cached answer.
// The response sits in an output register. When o_rsp.ready stays low the block
// still accepts a request and works it, then waits until the held response is
// taken before it loads the next one.
`default_nettype none
module tree_diameter_engine (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tde_req_if.sink    i_req,
    tde_rsp_if.source  o_rsp
);
    import tde_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    tde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    tde_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req_type  (i_req.req_type),
        .i_node_u    (i_req.node_u),
        .i_node_w    (i_req.node_w),
        .i_out_ready (o_rsp.ready),
        .o_stat      (stat),
        .o_out_valid (o_rsp.valid),
        .o_diameter  (o_rsp.diameter),
        .o_status    (o_rsp.status)
    );

    assign i_req.ready = in_ready;
endmodule
`default_nettype wire
